### design/rmd128_pkg.sv
`default_nettype none
package rmd128_pkg;

    // Standard initial chaining words.
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Left line message word selection.
    function automatic logic [3:0] sel_l(input logic [5:0] i);
        logic [3:0] t [64];
        t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,
              4'd14,4'd15,4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,
              4'd2,4'd14,4'd11,4'd8,4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,
              4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,
              4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2};
        return t[i];
    endfunction

    // Right line message word selection.
    function automatic logic [3:0] sel_r(input logic [5:0] i);
        logic [3:0] t [64];
        t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,
              4'd3,4'd12,4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,
              4'd4,4'd9,4'd1,4'd2,4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,
              4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,
              4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14};
        return t[i];
    endfunction

    // Left line rotate amounts.
    function automatic logic [4:0] rot_l(input logic [5:0] i);
        logic [4:0] t [64];
        t = '{5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,
              5'd7,5'd9,5'd8,5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,
              5'd9,5'd11,5'd7,5'd13,5'd12,5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,
              5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,5'd7,5'd5,5'd11,5'd12,5'd14,5'd15,5'd14,
              5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,5'd5,5'd12};
        return t[i];
    endfunction

    // Right line rotate amounts.
    function automatic logic [4:0] rot_r(input logic [5:0] i);
        logic [4:0] t [64];
        t = '{5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,
              5'd14,5'd12,5'd6,5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,
              5'd12,5'd7,5'd6,5'd15,5'd13,5'd11,5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,
              5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,5'd7,5'd5,5'd15,5'd5,5'd8,5'd11,
              5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,5'd15,5'd8};
        return t[i];
    endfunction

    function automatic logic [31:0] add_l(input logic [1:0] r);
        case (r)
            2'd0: return 32'h00000000;
            2'd1: return 32'h5A827999;
            2'd2: return 32'h6ED9EBA1;
            default: return 32'h8F1BBCDC;
        endcase
    endfunction

    function automatic logic [31:0] add_r(input logic [1:0] r);
        case (r)
            2'd0: return 32'h50A28BE6;
            2'd1: return 32'h5C4DD124;
            2'd2: return 32'h6D703EF3;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] mix(input logic [1:0] k, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        case (k)
            2'd0: return x ^ y ^ z;
            2'd1: return (x & y) | (~x & z);
            2'd2: return (x | ~y) ^ z;
            default: return (x & z) | (y & ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] d;
        d = {v, v} << s;
        return d[63:32];
    endfunction

endpackage
`default_nettype wire

### design/rmd128_wmem.sv
`default_nettype none
// Message word store: 16 words of 32 bits, byte-write, one read port
// with a registered output.
module rmd128_wmem
    import rmd128_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [3:0]  i_waddr,
    input  wire logic [3:0]  i_wbe,
    input  wire logic [31:0] i_wdata,
    input  wire logic [3:0]  i_raddr,
    output logic      [31:0] o_rdata
);
    logic [31:0] r_mem [16];

    // Byte-lane write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < 4; b++) begin
                if (i_wbe[b]) begin
                    r_mem[i_waddr][8*b +: 8] <= i_wdata[8*b +: 8];
                end
            end
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/rmd128_core.sv
`default_nettype none
// Round unit: one step of both lines per cycle while i_step is high, fed by two registered words.
module rmd128_core
    import rmd128_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic        i_step,
    input  wire logic [5:0]  i_idx,
    input  wire logic [31:0] i_wl,
    input  wire logic [31:0] i_wr,
    input  wire logic [127:0] i_cv,
    output logic      [127:0] o_fold
);
    logic [31:0] r_a, r_b, r_c, r_d, r_ar, r_br, r_cr, r_dr;
    logic [31:0] tl, tr;
    logic [1:0]  rnd;

    always_comb begin
        rnd = i_idx[5:4];
        tl = rotl(r_a + mix(rnd, r_b, r_c, r_d) + i_wl + add_l(rnd), rot_l(i_idx));
        tr = rotl(r_ar + mix(2'd3 - rnd, r_br, r_cr, r_dr) + i_wr + add_r(rnd),
                  rot_r(i_idx));
    end

    // Working registers of both lines.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            {r_d, r_c, r_b, r_a} <= i_cv;
            {r_dr, r_cr, r_br, r_ar} <= i_cv;
        end else if (i_step) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= tl;
            r_ar <= r_dr; r_dr <= r_cr; r_cr <= r_br; r_br <= tr;
        end
    end

    // New chaining value, word 0 in the low bits.
    always_comb begin
        o_fold[31:0]   = i_cv[63:32]  + r_c + r_dr;
        o_fold[63:32]  = i_cv[95:64]  + r_d + r_ar;
        o_fold[95:64]  = i_cv[127:96] + r_a + r_br;
        o_fold[127:96] = i_cv[31:0]   + r_b + r_cr;
    end
endmodule
`default_nettype wire

### design/ripemd128_hash_top.sv
`default_nettype none
// RIPEMD-128 hash, one message byte per request.
// Input stream: tdata = msg_byte, tuser = has_byte, tlast = last_byte.
// A request with has_byte low and tlast low is ignored. tlast ends the
// message (after its byte, if any); padding and length follow inside.
// Output stream: tdata = digest word (little-endian bytes), tuser = word
// number, tlast on the fourth word. Four words per message.
// Bytes are taken one per cycle until a block is full. Each 64-byte block
// is then loaded into the round unit, stepped with two word store reads
// per step and folded into the chaining value, and the store is then
// written back to zero. Input is held off while the block is compressed
// and the store is cleared.
// End of message adds a pad byte write, a length write into words 14
// and 15 and one or two compressions. The output register holds each
// word while the receiver stalls, and input stays held off until the
// fourth word is taken.
// Reset (synchronous, active low) restores the initial chaining value,
// zeroes the length and starts a clear of the word store.
module ripemd128_hash_top
    import rmd128_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // msg_byte
    input  wire logic        s_axis_tuser,   // has_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // digest_word
    output logic      [1:0]  m_axis_tuser,   // word_number
    output logic             m_axis_tlast    // last_word
);
    t_state r_state, n_state;
    logic [127:0] r_cv, n_cv;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_len, n_len;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_final, n_final;   // message ended, length block pending
    logic         r_lenpad, n_lenpad; // current block holds the length
    logic         r_padded, n_padded; // pad byte already written
    logic [1:0]   r_onum, n_onum;
    logic         r_ovld, n_ovld;

    logic         we;
    logic [3:0]   waddr, wbe, raddr;
    logic [31:0]  wdata, rdata;
    logic         core_load, core_step;
    logic [31:0]  r_wl;
    logic [127:0] fold;
    logic         acc;
    logic [5:0]   sidx;

    rmd128_wmem u_wmem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wbe(wbe),
        .i_wdata(wdata), .i_raddr(raddr), .o_rdata(rdata)
    );

    rmd128_core u_core (
        .i_clk(i_clk), .i_load(core_load), .i_step(core_step), .i_idx(sidx),
        .i_wl(r_wl), .i_wr(rdata), .i_cv(r_cv), .o_fold(fold)
    );

    // Left word is read in the cycle before the right and held.
    always_ff @(posedge i_clk) begin
        r_wl <= rdata;
    end

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    // ST_ROUND: even count reads the right word, odd count steps.
    assign sidx = r_cnt[6:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cv <= {H3, H2, H1, H0};
            r_fill <= '0;
            r_len <= '0;
            r_cnt <= '0;
            r_final <= 1'b0;
            r_lenpad <= 1'b0;
            r_padded <= 1'b0;
            r_onum <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cv <= n_cv;
            r_fill <= n_fill;
            r_len <= n_len;
            r_cnt <= n_cnt;
            r_final <= n_final;
            r_lenpad <= n_lenpad;
            r_padded <= n_padded;
            r_onum <= n_onum;
            r_ovld <= n_ovld;
        end
    end

    // Sequencer: byte fill, padding, compression, clear, digest output.
    always_comb begin
        n_state = r_state; n_cv = r_cv; n_fill = r_fill; n_len = r_len;
        n_cnt = r_cnt; n_final = r_final; n_lenpad = r_lenpad;
        n_padded = r_padded;
        n_onum = r_onum; n_ovld = r_ovld;
        we = 1'b0; waddr = r_fill[5:2]; wbe = '0; wdata = '0;
        raddr = sel_l(sidx);
        core_load = 1'b0; core_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (s_axis_tuser) begin
                        we = 1'b1;
                        wbe = 4'b0001 << r_fill[1:0];
                        wdata = {4{s_axis_tdata}};
                        n_fill = r_fill + 6'd1;
                        n_len = r_len + 64'd8;
                    end
                    n_final = s_axis_tlast;
                    // A full block is compressed first, even on the last byte.
                    if (s_axis_tuser && r_fill == 6'd63) begin
                        n_state = ST_LOAD; n_cnt = '0; core_load = 1'b1;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // Pad byte; block is otherwise zero already.
                we = 1'b1;
                wbe = 4'b0001 << r_fill[1:0];
                wdata = {4{PAD_BYTE}};
                n_padded = 1'b1;
                if (r_fill >= 6'd56) begin
                    n_lenpad = 1'b0;
                    n_state = ST_LOAD; n_cnt = '0; core_load = 1'b1;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                // Length in words 14 and 15, low word first.
                we = 1'b1; wbe = 4'hF;
                waddr = r_cnt[0] ? 4'd15 : 4'd14;
                wdata = r_cnt[0] ? r_len[63:32] : r_len[31:0];
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[0]) begin
                    n_lenpad = 1'b1;
                    n_state = ST_LOAD; n_cnt = '0; core_load = 1'b1;
                end
            end
            ST_LOAD: begin
                // Prime: read first left word.
                raddr = sel_l(6'd0);
                n_cnt = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                // Step on odd counts, when both words of the step are present,
                // and read the next left word; even counts read the right word.
                if (r_cnt[0]) begin
                    core_step = 1'b1;
                    raddr = sel_l(sidx + 6'd1);
                end else begin
                    raddr = sel_r(sidx);
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_cv = fold;
                n_fill = '0;
                n_cnt = '0;
                n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                we = 1'b1; wbe = 4'hF; waddr = r_cnt[3:0]; wdata = '0;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_cnt = '0;
                    if (r_final && r_lenpad) begin
                        n_state = ST_OUT; n_ovld = 1'b1; n_onum = '0;
                    end else if (r_final && r_padded) begin
                        n_state = ST_LEN;
                    end else if (r_final) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_onum = r_onum + 2'd1;
                    if (r_onum == 2'd3) begin
                        n_ovld = 1'b0;
                        n_cv = {H3, H2, H1, H0};
                        n_len = '0;
                        n_final = 1'b0;
                        n_lenpad = 1'b0;
                        n_padded = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_cv[32*r_onum +: 32];
    assign m_axis_tuser  = r_onum;
    assign m_axis_tlast  = (r_onum == 2'd3);
endmodule
`default_nettype wire

### tb/sv/ripemd128_hash_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module ripemd128_hash_top_tb;
    import rmd128_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        final_word;
    } t_digest_word;

    // Digest predictor and store of expected digest words.
    class digest_scoreboard;
        logic [31:0]  chain [4];
        logic [7:0]   block [64];
        int           fill;
        logic [63:0]  msg_bits;
        t_digest_word pending [$];
        int           errors;
        int           words_checked;
        int           messages;

        // Message word order and rotate amounts for both lines.
        static const int lsel [64] = '{
            0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
            7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
            3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
            1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2};
        static const int rsel [64] = '{
            5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
            6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
            15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
            8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14};
        static const int lrot [64] = '{
            11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
            7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
            11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
            11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12};
        static const int rrot [64] = '{
            8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
            9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
            9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
            15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8};

        function new();
            errors = 0;
            words_checked = 0;
            messages = 0;
            restart();
        endfunction

        function void restart();
            chain = '{H0, H1, H2, H3};
            foreach (block[i]) block[i] = 8'h00;
            fill = 0;
            msg_bits = 64'd0;
        endfunction

        function logic [31:0] rol(logic [31:0] v, int s);
            return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
        endfunction

        function logic [31:0] boolean_f(int k, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
            case (k)
                0: return x ^ y ^ z;
                1: return (x & y) | (~x & z);
                2: return (x | ~y) ^ z;
                default: return (x & z) | (y & ~z);
            endcase
        endfunction

        // One compression of the block store into the chaining value.
        function void compress();
            logic [31:0] w [16];
            logic [31:0] kl [4];
            logic [31:0] kr [4];
            logic [31:0] a, b, c, d, ar, br, cr, dr, t;
            int rnd;
            kl = '{32'h0, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
            kr = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h0};
            for (int i = 0; i < 16; i++)
                w[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            ar = a; br = b; cr = c; dr = d;
            for (int i = 0; i < 64; i++) begin
                rnd = i / 16;
                t = rol(a + boolean_f(rnd, b, c, d) + w[lsel[i]] + kl[rnd], lrot[i]);
                a = d; d = c; c = b; b = t;
                t = rol(ar + boolean_f(3 - rnd, br, cr, dr) + w[rsel[i]] + kr[rnd],
                        rrot[i]);
                ar = dr; dr = cr; cr = br; br = t;
            end
            t = chain[1] + c + dr;
            chain[1] = chain[2] + d + ar;
            chain[2] = chain[3] + a + br;
            chain[3] = chain[0] + b + cr;
            chain[0] = t;
            fill = 0;
            foreach (block[i]) block[i] = 8'h00;
        endfunction

        // Note an accepted request and queue any digest words it causes.
        function void note_request(logic [7:0] data, logic has_data, logic ends);
            if (has_data) begin
                block[fill] = data;
                fill++;
                msg_bits += 64'd8;
                if (fill == 64) compress();
            end
            if (!ends) return;
            block[fill] = PAD_BYTE;
            if (fill >= 56) compress();
            for (int i = 0; i < 8; i++) block[56 + i] = msg_bits[8*i +: 8];
            compress();
            for (int i = 0; i < 4; i++)
                pending.push_back('{chain[i], i[1:0], (i == 3)});
            messages++;
            restart();
        endfunction

        function void check_word(t_digest_word got);
            t_digest_word want;
            words_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.word !== want.word) begin
                $display("%0t: digest word expected %h actual %h", $time,
                         want.word, got.word);
                errors++;
            end
            if (got.index !== want.index) begin
                $display("%0t: word number expected %0d actual %0d", $time,
                         want.index, got.index);
                errors++;
            end
            if (got.final_word !== want.final_word) begin
                $display("%0t: last flag expected %0d actual %0d", $time,
                         want.final_word, got.final_word);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // msg_byte
    logic        s_axis_tuser;   // has_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [1:0]  m_axis_tuser;   // word_number
    logic        m_axis_tlast;   // last_word

    digest_scoreboard sb;
    int  requests_sent;
    bit  rx_throttle;

    ripemd128_hash_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Present one request from a falling edge and hold it until accepted.
    // The caller drops tvalid once the last request has gone.
    task automatic send_request(logic [7:0] data, logic has_data, logic ends,
                                bit allow_gap);
        int idle;
        idle = allow_gap ? gap_length() : 0;
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_data;
        s_axis_tlast  <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(data, has_data, ends);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, bit allow_gap, bit random_idles);
        for (int i = 0; i < len; i++) begin
            if (random_idles && $urandom_range(0, 15) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, allow_gap);
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, allow_gap);
        end
        if ($urandom_range(0, 1))
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, allow_gap);
        else
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1, allow_gap);
    endtask

    // Receiver: random stalls while throttled, sampled at the rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_throttle) begin
            m_axis_tready <= ($urandom_range(0, 24) == 0) ? 1'b0
                           : ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word('{m_axis_tdata, m_axis_tuser, m_axis_tlast});
    end

    initial begin
        #50_000_000;
        $display("timeout after %0d requests", requests_sent);
        $display("ripemd128_hash_top regression: fail");
        $finish;
    end

    initial begin
        int len;
        sb = new();
        requests_sent = 0;
        rx_throttle = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message, idle requests, one extreme byte each,
        // a two-byte message with the byte on the end request.
        send_request(8'h00, 1'b0, 1'b1, 0);
        send_request(8'hFF, 1'b0, 1'b0, 0);
        send_request(8'h00, 1'b1, 1'b1, 0);
        send_request(8'hFF, 1'b1, 1'b1, 0);
        send_request(8'hA5, 1'b1, 1'b0, 0);
        send_request(8'h5A, 1'b0, 1'b0, 0);
        send_request(8'h5A, 1'b1, 1'b1, 0);
        send_request(8'h80, 1'b0, 1'b1, 0);

        // Random: lengths around the padding boundaries and block edges,
        // trimmed near the end so the total stays close to 320 requests.
        rx_throttle = 1;
        while (requests_sent < 316) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(63, 65);
                3: len = $urandom_range(118, 121);
                default: len = $urandom_range(0, 40);
            endcase
            if (len > 318 - requests_sent) len = 318 - requests_sent;
            send_message(len, $urandom_range(0, 3) != 0, 1);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d requests covering %0d messages; checked %0d digest words.",
                 requests_sent, sb.messages, sb.words_checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ripemd128_hash_top regression: pass");
        end else begin
            $display("%0d mismatches, %0d words missing", sb.errors, sb.pending.size());
            $display("ripemd128_hash_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
